>>> rtl/deque_with_search_defines.svh
// ----------------------------------------------------------------------------
// Deque with search - assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_DEFINES_SVH
`define DEQUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DWS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dws_pkg.sv
// ----------------------------------------------------------------------------
// Deque with search - shared package
// Sizes, operation and status codes, and ring index arithmetic.
// ----------------------------------------------------------------------------
package dws_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int KIND_W   = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_SEARCH     = 3'd4,
      KIND_DUMP       = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // (base + off) mod DEPTH, valid for off <= DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // (base - 1) mod DEPTH
   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
      logic [IDX_W-1:0] res;
      if (base == '0) begin
         res = IDX_W'(DEPTH - 1);
      end else begin
         res = base - IDX_W'(1);
      end
      return res;
   endfunction

endpackage

>>> rtl/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search: push, pop, search and dump requests
// Push, no-op and error results go out of the decode state via the result
// register; pops go through the store read first. Search/dump walk one entry
// per cycle through the single store read port; dump results back to back; sync reset.
// ----------------------------------------------------------------------------
module deque_with_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dws_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [dws_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic [dws_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [dws_pkg::DATA_W-1:0]   rsp_data,
   output logic [dws_pkg::OCC_W-1:0]           rsp_occupancy,
   output logic                                rsp_last
);
   import dws_pkg::*;

   // Sequencer: IDLE takes a request, EXEC decodes it and does pushes and
   // status-only answers, POP waits for the read word, SCAN walks the ring.
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_POP  = 4'b0100,
      S_SCAN = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [DATA_W-1:0]    value_ff, value_in;
   logic [IDX_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 pend_ff, pend_in;

   // Element storage: one write port, one registered read port
   logic [DATA_W-1:0]    store_ff [DEPTH];
   logic [DATA_W-1:0]    rd_data_ff;
   logic                 rd_en, wr_en;
   logic [IDX_W-1:0]     rd_addr, wr_addr;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [OCC_W-1:0]     rsp_occ_ff;

   logic                 accept;
   logic                 is_empty, is_full, last_elem, hit;
   logic [CNT_W-1:0]     count_m1;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff >= CNT_W'(DEPTH));
   assign count_m1  = count_ff - CNT_W'(1);
   assign last_elem = (chk_idx_ff == count_m1);
   // The one shared compare: key against the word just read
   assign hit       = (rd_data_ff == value_ff);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      pend_in       = pend_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            // Latch the request and hand it to the decoder
            if (accept) begin
               kind_in  = req_kind;
               value_in = req_value;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_IDLE;
            unique case (kind_ff) inside
               KIND_PUSH_FRONT: begin
                  rsp_valid_in = 1'b1;
                  if (is_full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     // Step the front back one slot and write there
                     front_in = ring_dec(front_ff);
                     wr_en    = 1'b1;
                     wr_addr  = ring_dec(front_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               KIND_PUSH_BACK: begin
                  rsp_valid_in = 1'b1;
                  if (is_full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = ring_add(front_ff, count_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               KIND_POP_FRONT, KIND_POP_BACK: begin
                  if (is_empty) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     // Fetch the end element; answer once the word is back
                     rd_en    = 1'b1;
                     rd_addr  = (kind_ff == KIND_POP_FRONT) ? front_ff
                                                            : ring_add(front_ff, count_m1);
                     state_in = S_POP;
                  end
               end
               KIND_SEARCH, KIND_DUMP: begin
                  if (is_empty) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rd_idx_in = '0;
                     pend_in   = 1'b0;
                     state_in  = S_SCAN;
                  end
               end
               default: begin
                  // Unused codes: plain ok, state untouched
                  rsp_valid_in = 1'b1;
               end
            endcase
         end

         S_POP: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data_ff;
            count_in     = count_m1;
            if (kind_ff == KIND_POP_FRONT) begin
               front_in = ring_add(front_ff, CNT_W'(1));
            end
            state_in = S_IDLE;
         end

         S_SCAN: begin
            // Issue the next read while checking the word from the last one
            pend_in = 1'b0;
            if (rd_idx_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = ring_add(front_ff, rd_idx_ff);
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
               chk_idx_in = rd_idx_ff;
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               if (kind_ff == KIND_DUMP) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = rd_data_ff;
                  rsp_last_in  = last_elem;
                  if (last_elem) begin
                     state_in = S_IDLE;
                  end
               end else if (hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = value_ff;
                  state_in     = S_IDLE;
               end else if (last_elem) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
                  state_in      = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and walk payload; result fields load only when a result is made
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_occ_ff    <= OCC_W'(count_in);
      end
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> rtl/dws_checker.sv
// ----------------------------------------------------------------------------
// Deque with search - port checker
// Watches the top-level ports for sequencing and result-format slips.
// ----------------------------------------------------------------------------
`include "deque_with_search_defines.svh"

module dws_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                rsp_strobe,
   input  logic [dws_pkg::STATUS_W-1:0]        rsp_status,
   input  logic signed [dws_pkg::DATA_W-1:0]   rsp_data,
   input  logic                                rsp_last
);
   import dws_pkg::*;

   `DWS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
   `DWS_ASSERT_NEXT(a_dump_burst, rsp_strobe && !rsp_last, rsp_strobe, "gap inside dump burst")
   `DWS_ASSERT_NOW(a_err_data, rsp_strobe && (rsp_status != ST_OK), rsp_data == '0, "error result carries data")
   `DWS_ASSERT_NOW(a_last_idle, rsp_strobe && rsp_last, !busy, "busy after final result")
   `DWS_ASSERT_NOW(a_mid_busy, rsp_strobe && !rsp_last, busy, "idle inside dump burst")

endmodule

bind deque_with_search dws_checker u_dws_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_data   (rsp_data),
   .rsp_last   (rsp_last)
);

>>> sim/deque_with_search_test.sv
// ----------------------------------------------------------------------------
// Deque with search - block-level test
// Drives push, pop, search, dump and undefined requests through the command
// port with random idle gaps, mirrors the ring buffer in a local model and
// checks every response field by field, in order.
// ----------------------------------------------------------------------------
module deque_with_search_test;

   import dws_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 12;
   localparam int MAX_GAP       = 17;
   // leave margin on top of the longest search/dump walk
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int CYCLE_LIMIT   = 200000;

   // codes the package leaves undefined; the block treats them as no-ops
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   // sender idle policy for the current phase
   localparam int IDLE_RANDOM = 0;
   localparam int IDLE_NONE   = 1;
   localparam int IDLE_MIXED  = 2;

   typedef struct {
      status_type                 status;
      logic signed [DATA_W-1:0]   data;
      logic [OCC_W-1:0]           occupancy;
      logic                       last;
   } deque_rsp_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [KIND_W-1:0]          req_kind;
   logic signed [DATA_W-1:0]   req_value;
   logic                       rsp_strobe;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0]   rsp_data;
   logic [OCC_W-1:0]           rsp_occupancy;
   logic                       rsp_last;

   // mirror of the ring buffer: contents, front position and fill level
   logic signed [DATA_W-1:0]   ring_copy [DEPTH];
   int                         ring_front;
   int                         ring_count;

   // responses the mirror says are still owed by the block, oldest first
   deque_rsp_type              predicted_rsps [$];
   deque_rsp_type              due;

   int                         idle_mode;
   int                         cycle_count;
   int                         mismatches;
   int                         rsps_checked;
   int                         peak_fill;
   int                         full_hits;
   int                         empty_hits;
   int                         kind_seen [8];

   deque_with_search dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Bound the run: a hung handshake or a lost response ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still owed",
                  cycle_count, predicted_rsps.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Mirror model
   // --------------------------------------------------------------------------

   // Queue one owed response; occupancy is the fill level after the request.
   function automatic void owe_rsp(input status_type status,
                                   input logic signed [DATA_W-1:0] data,
                                   input logic last);
      deque_rsp_type r;
      r.status    = status;
      r.data      = data;
      r.occupancy = OCC_W'(ring_count);
      r.last      = last;
      predicted_rsps.push_back(r);
   endfunction

   // Apply one accepted request to the mirror and queue its responses.
   function automatic void apply_deque_op(input logic [KIND_W-1:0] kind,
                                          input logic signed [DATA_W-1:0] value);
      logic signed [DATA_W-1:0] word;
      bit                       hit;
      kind_seen[kind]++;
      case (kind)
         KIND_PUSH_FRONT: begin
            if (ring_count >= DEPTH) begin
               full_hits++;
               owe_rsp(ST_FULL, '0, 1'b1);
            end else begin
               ring_front = (ring_front + DEPTH - 1) % DEPTH;
               ring_copy[ring_front] = value;
               ring_count++;
               owe_rsp(ST_OK, '0, 1'b1);
            end
         end
         KIND_PUSH_BACK: begin
            if (ring_count >= DEPTH) begin
               full_hits++;
               owe_rsp(ST_FULL, '0, 1'b1);
            end else begin
               ring_copy[(ring_front + ring_count) % DEPTH] = value;
               ring_count++;
               owe_rsp(ST_OK, '0, 1'b1);
            end
         end
         KIND_POP_FRONT: begin
            if (ring_count == 0) begin
               empty_hits++;
               owe_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               word = ring_copy[ring_front];
               ring_front = (ring_front + 1) % DEPTH;
               ring_count--;
               owe_rsp(ST_OK, word, 1'b1);
            end
         end
         KIND_POP_BACK: begin
            if (ring_count == 0) begin
               empty_hits++;
               owe_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               word = ring_copy[(ring_front + ring_count - 1) % DEPTH];
               ring_count--;
               owe_rsp(ST_OK, word, 1'b1);
            end
         end
         KIND_SEARCH: begin
            if (ring_count == 0) begin
               empty_hits++;
               owe_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               hit = 1'b0;
               for (int i = 0; i < ring_count; i++) begin
                  if (ring_copy[(ring_front + i) % DEPTH] == value) begin
                     hit = 1'b1;
                  end
               end
               if (hit) begin
                  owe_rsp(ST_OK, value, 1'b1);
               end else begin
                  owe_rsp(ST_NOT_FOUND, '0, 1'b1);
               end
            end
         end
         KIND_DUMP: begin
            if (ring_count == 0) begin
               empty_hits++;
               owe_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               // one response per element, front to back, last on the final one
               for (int i = 0; i < ring_count; i++) begin
                  owe_rsp(ST_OK, ring_copy[(ring_front + i) % DEPTH],
                          (i == ring_count - 1));
               end
            end
         end
         default: begin
            owe_rsp(ST_OK, '0, 1'b1);
         end
      endcase
      if (ring_count > peak_fill) begin
         peak_fill = ring_count;
      end
   endfunction

   // --------------------------------------------------------------------------
   // Response checker: the block cannot be held off, so take every strobe.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (predicted_rsps.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response status=%0d data=%0d occupancy=%0d last=%0b",
                     $time, rsp_status, rsp_data, rsp_occupancy, rsp_last);
         end else begin
            due = predicted_rsps.pop_front();
            rsps_checked++;
            if (rsp_status !== due.status) begin
               mismatches++;
               $display("%0t: status expected %0d, got %0d", $time, due.status, rsp_status);
            end
            if (rsp_data !== due.data) begin
               mismatches++;
               $display("%0t: data expected %0d, got %0d", $time, due.data, rsp_data);
            end
            if (rsp_occupancy !== due.occupancy) begin
               mismatches++;
               $display("%0t: occupancy expected %0d, got %0d",
                        $time, due.occupancy, rsp_occupancy);
            end
            if (rsp_last !== due.last) begin
               mismatches++;
               $display("%0t: last expected %0b, got %0b", $time, due.last, rsp_last);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Sender
   // --------------------------------------------------------------------------

   function automatic int draw_gap();
      int gap;
      case (idle_mode)
         IDLE_NONE:  gap = 0;
         IDLE_MIXED: gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_GAP);
         default:    gap = $urandom_range(0, MAX_GAP);
      endcase
      return gap;
   endfunction

   // Send one request and return at the edge that accepts it. Start is left
   // high after acceptance so back-to-back requests need no reassertion; any
   // idle stretch lowers it at the very next falling edge, before the block
   // can see it again.
   task automatic issue_request(input logic [KIND_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     = 1'b1;
      req_kind  = kind;
      req_value = value;
      // hold the request until an edge finds the block free
      do @(posedge clock); while (busy !== 1'b0);
      apply_deque_op(kind, value);
   endtask

   // Drop start, hold until every owed response is in, then let the block
   // finish any walk still in flight.
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (predicted_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly full-range random words, sometimes a corner value.
   function automatic logic signed [DATA_W-1:0] draw_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 19))
         0:       v = {1'b1, {(DATA_W-1){1'b0}}};
         1:       v = {1'b0, {(DATA_W-1){1'b1}}};
         2:       v = '0;
         3:       v = '1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Pick a search key: usually one held in the ring, so searches hit.
   function automatic logic signed [DATA_W-1:0] draw_key();
      logic signed [DATA_W-1:0] k;
      if (ring_count > 0 && $urandom_range(0, 99) < 60) begin
         k = ring_copy[(ring_front + $urandom_range(0, ring_count - 1)) % DEPTH];
      end else begin
         k = draw_value();
      end
      return k;
   endfunction

   // One random request; push_pct steers the ring toward full or empty.
   task automatic issue_random(input int push_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
         issue_request(($urandom_range(0, 1) == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                       draw_value());
      end else if (r < push_pct + 12) begin
         issue_request(KIND_SEARCH, draw_key());
      end else if (r < push_pct + 18) begin
         issue_request(KIND_DUMP, draw_value());
      end else if (r < push_pct + 21) begin
         issue_request(($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI,
                       draw_value());
      end else begin
         issue_request(($urandom_range(0, 1) == 0) ? KIND_POP_FRONT : KIND_POP_BACK,
                       draw_value());
      end
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // Every operation on an empty ring: pops and search report empty, dump
   // gives a single empty response, an undefined code is a no-op.
   task automatic test_empty_ring();
      idle_mode = IDLE_RANDOM;
      issue_request(KIND_POP_FRONT, '1);
      issue_request(KIND_POP_BACK, '0);
      issue_request(KIND_SEARCH, '0);
      issue_request(KIND_DUMP, '1);
      issue_request(KIND_SPARE_LO, 32'h5555_5555);
   endtask

   // Fill from both ends with corner values, push into a full ring at both
   // ends, dump all sixteen, search a held key, then pop from each end.
   task automatic test_fill_to_full();
      logic signed [DATA_W-1:0] corner [8];
      corner[0] = {1'b1, {(DATA_W-1){1'b0}}};
      corner[1] = {1'b0, {(DATA_W-1){1'b1}}};
      corner[2] = '0;
      corner[3] = '1;
      corner[4] = 32'h5555_5555;
      corner[5] = 32'hAAAA_AAAA;
      corner[6] = 32'sd1;
      corner[7] = 32'h8000_0001;
      idle_mode = IDLE_MIXED;
      for (int i = 0; i < DEPTH; i++) begin
         issue_request(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                       (i < 8) ? corner[i] : draw_value());
      end
      issue_request(KIND_PUSH_FRONT, 32'sd42);
      issue_request(KIND_PUSH_BACK, -32'sd42);
      issue_request(KIND_DUMP, '0);
      issue_request(KIND_SEARCH, corner[0]);
      issue_request(KIND_POP_FRONT, '0);
      issue_request(KIND_POP_BACK, '0);
      // pause the sender until the block has answered everything
      wait_drained();
   endtask

   // Push-heavy random traffic with full idle gaps: reaches the full ring.
   task automatic test_grow_random();
      idle_mode = IDLE_RANDOM;
      repeat (30) issue_random(70);
      wait_drained();
   endtask

   // Pop-heavy traffic back to back: drains through wraparound to empty.
   task automatic test_shrink_burst();
      idle_mode = IDLE_NONE;
      repeat (40) issue_random(25);
      wait_drained();
   endtask

   // Balanced traffic, gaps on roughly half the requests.
   task automatic test_mixed_traffic();
      idle_mode = IDLE_MIXED;
      repeat (25) issue_random(42);
      wait_drained();
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_kind    = KIND_PUSH_FRONT;
      req_value   = '0;
      idle_mode   = IDLE_RANDOM;
      cycle_count = 0;
      mismatches  = 0;
      rsps_checked = 0;
      peak_fill   = 0;
      full_hits   = 0;
      empty_hits  = 0;
      ring_front  = 0;
      ring_count  = 0;
      for (int i = 0; i < 8; i++) begin
         kind_seen[i] = 0;
      end
      for (int i = 0; i < DEPTH; i++) begin
         ring_copy[i] = '0;
      end

      // hold reset, release it on a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_ring();
      test_fill_to_full();
      test_grow_random();
      test_shrink_burst();
      test_mixed_traffic();

      $display("Covered pushes %0d/%0d, pops %0d/%0d, searches %0d, dumps %0d, no-ops %0d",
               kind_seen[KIND_PUSH_FRONT], kind_seen[KIND_PUSH_BACK],
               kind_seen[KIND_POP_FRONT], kind_seen[KIND_POP_BACK],
               kind_seen[KIND_SEARCH], kind_seen[KIND_DUMP],
               kind_seen[KIND_SPARE_LO] + kind_seen[KIND_SPARE_HI]);
      $display("Checked %0d responses; peak fill %0d, full rejects %0d, empty reports %0d",
               rsps_checked, peak_fill, full_hits, empty_hits);
      if (mismatches == 0 && predicted_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
